### src/cda_pkg.sv
// shared types and constants of the calendar date unit
package cda_pkg;

    typedef enum logic [1:0] {
        KIND_TO_DATE   = 2'd0,
        KIND_TO_SERIAL = 2'd1,
        KIND_NORMALIZE = 2'd2,
        KIND_ADD       = 2'd3
    } kind_t;

    localparam int unsigned DAYS_400 = 146097;
    localparam int unsigned DAYS_100 = 36524;
    localparam int unsigned DAYS_4   = 1461;
    localparam int unsigned DAYS_1   = 365;

    // floor reciprocals, quotient comes out low by at most one
    localparam logic [24:0] RCP_400 = 25'((64'd1 << 42) / 64'd146097);
    localparam logic [14:0] RCP_100 = 15'((64'd1 << 30) / 64'd36524);
    localparam logic [17:0] RCP_4   = 18'((64'd1 << 28) / 64'd1461);
    localparam logic [13:0] RCP_1   = 14'((64'd1 << 22) / 64'd365);

    // control that travels with a date through the back stages
    typedef struct packed {
        logic        sat;
        logic        flag;
        logic [21:0] serial;
    } cda_ctl_t;

    // day of year before month mi (0 based), leap day counted from march on
    function automatic logic [8:0] month_start(input logic [3:0] mi, input logic leap);
        logic [8:0] base;
        begin
            case (mi)
                4'd0:    base = 9'd0;
                4'd1:    base = 9'd31;
                4'd2:    base = 9'd59;
                4'd3:    base = 9'd90;
                4'd4:    base = 9'd120;
                4'd5:    base = 9'd151;
                4'd6:    base = 9'd181;
                4'd7:    base = 9'd212;
                4'd8:    base = 9'd243;
                4'd9:    base = 9'd273;
                4'd10:   base = 9'd304;
                4'd11:   base = 9'd334;
                default: base = 9'd0;
            endcase
            month_start = base + {8'd0, (leap && (mi >= 4'd2))};
        end
    endfunction

endpackage

### src/calendar_date_arithmetic_core.sv
// proleptic gregorian date unit: serial/date conversion, normalize, add offset
//
// usage
//   one command channel in: an operation is transferred at a rising edge where
//   start is high and busy is low. busy stays low, so a new operation may be
//   issued in every cycle.
//   kind selects serial to date, date to serial, normalize a signed triple,
//   or add the signed day offset in in_serial to the date.
//   one result out per operation: done is high for exactly one cycle while
//   out_day, out_month, out_year, out_serial and out_of_range hold the result.
//   the receiver cannot stall, so nothing holds the pipeline.
// pipeline and throughput
//   a fifteen stage pipeline: results leave in issue order, one per cycle at
//   full rate.
//   the depth is set by the serial to date split into 400/100/4/1 year
//   blocks, each a reciprocal multiply stage and a correction stage.
// reset
//   rst_n clears the valid bits only; operations in flight are dropped.
// out_of_range is set when the result passes MAX_YEAR, or falls below year 1 for
// date to serial and normalize; any such result reads 1/1/1 with serial 1.
module calendar_date_arithmetic_core
    import cda_pkg::*;
#(
    parameter int unsigned MAX_YEAR = 9999
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         kind,
    input  logic signed [16:0] in_day,
    input  logic signed [12:0] in_month,
    input  logic [13:0]        in_year,
    input  logic signed [22:0] in_serial,
    output logic               done,
    output logic [4:0]         out_day,
    output logic [3:0]         out_month,
    output logic [13:0]        out_year,
    output logic [21:0]        out_serial,
    output logic               out_of_range
);

    // last serial of the year MAX_YEAR
    localparam int unsigned LAST = 365 * MAX_YEAR + MAX_YEAR / 4 - MAX_YEAR / 100
                                   + MAX_YEAR / 400;
    localparam int NSTG = 14;

    logic [NSTG:1] v_reg, v_next;
    logic          done_reg;

    // stage 1: month carry approximation
    kind_t              s1_kind_reg;
    logic signed [16:0] s1_d_reg;
    logic [13:0]        s1_y_reg;
    logic signed [22:0] s1_s_reg;
    logic [13:0]        s1_x12_reg;
    logic [9:0]         s1_q12_reg;
    // stage 2: year split for leap and day count
    kind_t              s2_kind_reg;
    logic signed [16:0] s2_d_reg;
    logic signed [22:0] s2_s_reg;
    logic [3:0]         s2_mi_reg;
    logic [14:0]        s2_tp_reg;
    logic [7:0]         s2_hq_reg;
    logic [7:0]         s2_hy_reg;
    // stage 3: days before year
    kind_t              s3_kind_reg;
    logic signed [16:0] s3_d_reg;
    logic signed [22:0] s3_s_reg;
    logic [3:0]         s3_mi_reg;
    logic               s3_leap_reg;
    logic signed [26:0] s3_dby_reg;
    // stage 4: total serial
    logic signed [26:0] s4_total_reg;
    logic               s4_clamp_reg;
    // stages 5..14
    cda_ctl_t           ctl_reg [5:NSTG];
    logic [24:0]        s5_r_reg, s6_r_reg;
    logic [7:0]         s6_qa_reg;
    logic [7:0]         q400_reg [7:NSTG-1];
    logic [17:0]        s7_r_reg, s8_r_reg;
    logic [2:0]         s8_qa_reg;
    logic [1:0]         q100_reg [9:NSTG-1];
    logic [15:0]        s9_r_reg, s10_r_reg;
    logic [4:0]         s10_qa_reg;
    logic [4:0]         q4_reg [11:NSTG-1];
    logic [10:0]        s11_r_reg, s12_r_reg;
    logic [2:0]         s12_qa_reg;
    logic [1:0]         q1_reg [13:NSTG-1];
    logic [8:0]         s13_r_reg, s14_r_reg;
    logic [15:0]        s14_year_reg;
    logic               s14_leap_reg;
    logic [3:0]         s14_mo_reg;
    // output registers
    logic [4:0]         day_reg;
    logic [3:0]         month_reg;
    logic [13:0]        year_reg;
    logic [21:0]        serial_reg;
    logic               oor_reg;

    // combinational per stage
    logic [13:0]        x12_c;
    logic [27:0]        p12_c;
    logic [3:0]         mi_c;
    logic [14:0]        tp_c, yp_c, yp3_c;
    logic [27:0]        phq_c, phy_c;
    logic               rz_c, leap3_c;
    logic signed [26:0] dby_c, add_c, total_c;
    logic               nonpos_c, big_c;
    cda_ctl_t           ctl_c;
    logic [24:0]        r5_c;
    logic [49:0]        p400_c;
    logic [24:0]        rem400_c;
    logic               inc400_c;
    logic [32:0]        p100_c;
    logic [17:0]        rem100_c;
    logic               inc100_c;
    logic [2:0]         q100_c;
    logic [16:0]        r100_c;
    logic [33:0]        p4_c;
    logic [15:0]        rem4_c;
    logic               inc4_c;
    logic [24:0]        p1_c;
    logic [10:0]        rem1_c;
    logic               inc1_c;
    logic [2:0]         q1_c;
    logic [9:0]         r1_c;
    logic [15:0]        year_c;
    logic               leap14_c;
    logic [3:0]         mo_c;
    logic [4:0]         day_c;

    assign busy = 1'b0;

    always_comb
    begin
        // stage 1: (month-1) offset by 342 years of months, divide by 12
        x12_c = {in_month[12], in_month} + 14'd4103;
        p12_c = 28'(x12_c) * 28'd10923;

        // stage 2: month index, year block offset by 400 years
        mi_c  = 4'(s1_x12_reg - 14'(s1_q12_reg) * 14'd12);
        tp_c  = 15'(s1_y_reg) + 15'(s1_q12_reg) + 15'd57;
        yp_c  = tp_c + 15'd1;
        phq_c = 28'(tp_c) * 28'd5243;
        phy_c = 28'(yp_c) * 28'd5243;

        // stage 3: leap flag and days in the years before
        yp3_c   = s2_tp_reg + 15'd1;
        rz_c    = (yp3_c == 15'(s2_hy_reg) * 15'd100);
        leap3_c = ((yp3_c[1:0] == 2'd0) && !rz_c) || (rz_c && (s2_hy_reg[1:0] == 2'd0));
        dby_c   = 27'(s2_tp_reg) * 27'd365 + 27'(s2_tp_reg[14:2]) - 27'(s2_hq_reg)
                  + 27'(s2_hq_reg[7:2]) - 27'd146097;

        // stage 4: linear day count
        add_c = s3_dby_reg + 27'(month_start(s3_mi_reg, s3_leap_reg)) + 27'(s3_d_reg);
        if (s3_kind_reg == KIND_ADD)
        begin
            add_c = add_c + 27'(s3_s_reg);
        end
        total_c = (s3_kind_reg == KIND_TO_DATE) ? 27'(s3_s_reg) : add_c;

        // stage 5: range check and saturation
        nonpos_c      = (s4_total_reg <= 27'sd0);
        big_c         = (s4_total_reg > $signed(27'(LAST)));
        ctl_c.sat     = nonpos_c || big_c;
        ctl_c.flag    = big_c || (nonpos_c && !s4_clamp_reg);
        ctl_c.serial  = ctl_c.sat ? 22'd1 : 22'(s4_total_reg);
        r5_c          = ctl_c.sat ? 25'd0 : 25'(s4_total_reg - 27'sd1);

        // stage 6: 400 year quotient estimate
        p400_c = 50'(s5_r_reg) * 50'(RCP_400);

        // stage 7: correct 400 year quotient
        rem400_c = s6_r_reg - 25'(s6_qa_reg) * 25'(DAYS_400);
        inc400_c = (rem400_c >= 25'(DAYS_400));

        // stage 8: 100 year quotient estimate
        p100_c = 33'(s7_r_reg) * 33'(RCP_100);

        // stage 9: correct and clamp to three centuries
        rem100_c = s8_r_reg - 18'(s8_qa_reg) * 18'(DAYS_100);
        inc100_c = (rem100_c >= 18'(DAYS_100));
        q100_c   = s8_qa_reg + 3'(inc100_c);
        r100_c   = inc100_c ? 17'(rem100_c - 18'(DAYS_100)) : 17'(rem100_c);
        if (q100_c == 3'd4)
        begin
            q100_c = 3'd3;
            r100_c = r100_c + 17'(DAYS_100);
        end

        // stage 10: 4 year quotient estimate
        p4_c = 34'(s9_r_reg) * 34'(RCP_4);

        // stage 11: correct 4 year quotient
        rem4_c = s10_r_reg - 16'(s10_qa_reg) * 16'(DAYS_4);
        inc4_c = (rem4_c >= 16'(DAYS_4));

        // stage 12: year quotient estimate
        p1_c = 25'(s11_r_reg) * 25'(RCP_1);

        // stage 13: correct and clamp to three years
        rem1_c = s12_r_reg - 11'(s12_qa_reg) * 11'(DAYS_1);
        inc1_c = (rem1_c >= 11'(DAYS_1));
        q1_c   = s12_qa_reg + 3'(inc1_c);
        r1_c   = inc1_c ? 10'(rem1_c - 11'(DAYS_1)) : 10'(rem1_c);
        if (q1_c == 3'd4)
        begin
            q1_c = 3'd3;
            r1_c = r1_c + 10'(DAYS_1);
        end

        // stage 14: year number, leap and month search
        year_c   = 16'(q400_reg[13]) * 16'd400 + 16'(q100_reg[13]) * 16'd100
                   + 16'(q4_reg[13]) * 16'd4 + 16'(q1_reg[13]) + 16'd1;
        leap14_c = (q1_reg[13] == 2'd3) && ((q4_reg[13] != 5'd24) || (q100_reg[13] == 2'd3));
        mo_c     = 4'd0;
        for (int i = 1; i < 12; i++)
        begin
            if (month_start(4'(i), leap14_c) <= s13_r_reg)
            begin
                mo_c = mo_c + 4'd1;
            end
        end

        // stage 15: day of month
        day_c = 5'(s14_r_reg - month_start(s14_mo_reg, s14_leap_reg)) + 5'd1;

        v_next = {v_reg[NSTG-1:1], start};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg    <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            v_reg    <= v_next;
            done_reg <= v_reg[NSTG];
        end
    end

    always_ff @(posedge clk)
    begin
        s1_kind_reg  <= kind_t'(kind);
        s1_d_reg     <= in_day;
        s1_y_reg     <= in_year;
        s1_s_reg     <= in_serial;
        s1_x12_reg   <= x12_c;
        s1_q12_reg   <= p12_c[26:17];

        s2_kind_reg  <= s1_kind_reg;
        s2_d_reg     <= s1_d_reg;
        s2_s_reg     <= s1_s_reg;
        s2_mi_reg    <= mi_c;
        s2_tp_reg    <= tp_c;
        s2_hq_reg    <= phq_c[26:19];
        s2_hy_reg    <= phy_c[26:19];

        s3_kind_reg  <= s2_kind_reg;
        s3_d_reg     <= s2_d_reg;
        s3_s_reg     <= s2_s_reg;
        s3_mi_reg    <= s2_mi_reg;
        s3_leap_reg  <= leap3_c;
        s3_dby_reg   <= dby_c;

        s4_total_reg <= total_c;
        s4_clamp_reg <= (s3_kind_reg == KIND_TO_DATE) || (s3_kind_reg == KIND_ADD);

        ctl_reg[5]   <= ctl_c;
        for (int k = 6; k <= NSTG; k++)
        begin
            ctl_reg[k] <= ctl_reg[k-1];
        end
        s5_r_reg     <= r5_c;

        s6_r_reg     <= s5_r_reg;
        s6_qa_reg    <= p400_c[49:42];

        q400_reg[7]  <= s6_qa_reg + 8'(inc400_c);
        for (int k = 8; k < NSTG; k++)
        begin
            q400_reg[k] <= q400_reg[k-1];
        end
        s7_r_reg     <= inc400_c ? 18'(rem400_c - 25'(DAYS_400)) : 18'(rem400_c);

        s8_r_reg     <= s7_r_reg;
        s8_qa_reg    <= p100_c[32:30];

        q100_reg[9]  <= q100_c[1:0];
        for (int k = 10; k < NSTG; k++)
        begin
            q100_reg[k] <= q100_reg[k-1];
        end
        s9_r_reg     <= r100_c[15:0];

        s10_r_reg    <= s9_r_reg;
        s10_qa_reg   <= p4_c[32:28];

        q4_reg[11]   <= s10_qa_reg + 5'(inc4_c);
        for (int k = 12; k < NSTG; k++)
        begin
            q4_reg[k] <= q4_reg[k-1];
        end
        s11_r_reg    <= inc4_c ? 11'(rem4_c - 16'(DAYS_4)) : 11'(rem4_c);

        s12_r_reg    <= s11_r_reg;
        s12_qa_reg   <= p1_c[24:22];

        q1_reg[13]   <= q1_c[1:0];
        s13_r_reg    <= r1_c[8:0];

        s14_r_reg    <= s13_r_reg;
        s14_year_reg <= year_c;
        s14_leap_reg <= leap14_c;
        s14_mo_reg   <= mo_c;

        // saturated results read as 1/1/1
        if (ctl_reg[NSTG].sat)
        begin
            day_reg   <= 5'd1;
            month_reg <= 4'd1;
            year_reg  <= 14'd1;
        end
        else
        begin
            day_reg   <= day_c;
            month_reg <= s14_mo_reg + 4'd1;
            year_reg  <= s14_year_reg[13:0];
        end
        serial_reg <= ctl_reg[NSTG].serial;
        oor_reg    <= ctl_reg[NSTG].flag;
    end

    assign done         = done_reg;
    assign out_day      = day_reg;
    assign out_month    = month_reg;
    assign out_year     = year_reg;
    assign out_serial   = serial_reg;
    assign out_of_range = oor_reg;

endmodule

### tb/sv/calendar_date_arithmetic_core_tb.sv
// testbench for the calendar date unit: directed table plus random ops checked by a predictor
`timescale 1ns / 100ps

module calendar_date_arithmetic_core_tb;
    import cda_pkg::*;

    localparam int unsigned MAX_YEAR    = 9999;
    localparam int          N_RANDOM    = 1630;
    localparam int          CYCLE_LIMIT = 400000;
    localparam int          DRAIN_WAIT  = 40;

    // one date result as it appears on the output ports
    typedef struct packed {
        logic [4:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
        logic [21:0] serial;
        logic        oor;
    } date_res_t;

    // directed stimulus row, typed expectation only where it is obvious
    typedef struct {
        kind_t     op;
        int        d;
        int        m;
        int        y;
        int        s;
        bit        typed;
        date_res_t res;
    } date_row_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         kind;
    logic signed [16:0] in_day;
    logic signed [12:0] in_month;
    logic [13:0]        in_year;
    logic signed [22:0] in_serial;
    logic               done;
    logic [4:0]         out_day;
    logic [3:0]         out_month;
    logic [13:0]        out_year;
    logic [21:0]        out_serial;
    logic               out_of_range;

    // typed expectation that rides along with the command being offered
    bit        row_typed;
    date_res_t row_res;

    date_res_t pending_dates[$];
    int        mismatches;
    int        cycles;

    calendar_date_arithmetic_core #(.MAX_YEAR(MAX_YEAR)) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .kind         (kind),
        .in_day       (in_day),
        .in_month     (in_month),
        .in_year      (in_year),
        .in_serial    (in_serial),
        .done         (done),
        .out_day      (out_day),
        .out_month    (out_month),
        .out_year     (out_year),
        .out_serial   (out_serial),
        .out_of_range (out_of_range)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // ------------------------------------------------------------------
    // date arithmetic predictor
    // ------------------------------------------------------------------

    // floor division, rounds toward minus infinity
    function automatic longint floor_div(input longint a, input longint b);
        longint q;
        begin
            q = a / b;
            if ((a % b) != 0 && a < 0)
                q = q - 1;
            return q;
        end
    endfunction

    // gregorian rule applied to every year, year 0 included
    function automatic bit leap_year(input longint y);
        return (y % 400 == 0) || (y % 4 == 0 && y % 100 != 0);
    endfunction

    // days in all years before y, negative for y below 1
    function automatic longint days_to_year(input longint y);
        longint t;
        begin
            t = y - 1;
            return 365 * t + floor_div(t, 4) - floor_div(t, 100) + floor_div(t, 400);
        end
    endfunction

    function automatic longint days_to_month(input longint mi);
        case (mi)
            0: return 0;    1: return 31;   2: return 59;   3: return 90;
            4: return 120;  5: return 151;  6: return 181;  7: return 212;
            8: return 243;  9: return 273;  10: return 304; default: return 334;
        endcase
    endfunction

    function automatic longint month_days(input longint mi, input bit lp);
        case (mi)
            1:              return lp ? 29 : 28;
            3, 5, 8, 10:    return 30;
            default:        return 31;
        endcase
    endfunction

    // linear day number of a possibly out of range triple
    function automatic longint day_number(input longint d, input longint m, input longint y);
        longint carry;
        longint n;
        begin
            carry = floor_div(m - 1, 12);
            y = y + carry;
            m = m - carry * 12;
            n = days_to_year(y) + days_to_month(m - 1) + d;
            if (m > 2 && leap_year(y))
                n = n + 1;
            return n;
        end
    endfunction

    // split a valid serial into 400/100/4/1 year blocks, then walk months
    function automatic date_res_t serial_date(input longint s);
        longint    r;
        longint    q400, q100, q4, q1, y, mi;
        bit        lp;
        date_res_t res;
        begin
            r = s - 1;
            q400 = r / 146097;
            r = r % 146097;
            q100 = r / 36524;
            if (q100 > 3)
                q100 = 3;
            r = r - q100 * 36524;
            q4 = r / 1461;
            r = r % 1461;
            q1 = r / 365;
            if (q1 > 3)
                q1 = 3;
            r = r - q1 * 365;
            y = 400 * q400 + 100 * q100 + 4 * q4 + q1 + 1;
            lp = leap_year(y);
            mi = 0;
            while (mi < 11 && r >= month_days(mi, lp)) begin
                r = r - month_days(mi, lp);
                mi = mi + 1;
            end
            res.day    = 5'(r + 1);
            res.month  = 4'(mi + 1);
            res.year   = 14'(y);
            res.serial = 22'(s);
            res.oor    = 1'b0;
            return res;
        end
    endfunction

    function automatic date_res_t predict_date(input logic [1:0] op, input longint d,
                                               input longint m, input longint y,
                                               input longint s);
        longint    total;
        bit        low_ok;
        date_res_t res;
        begin
            res = '{day: 5'd1, month: 4'd1, year: 14'd1, serial: 22'd1, oor: 1'b0};
            if (op == KIND_TO_DATE) begin
                total  = s;
                low_ok = 1'b1;
            end else begin
                total  = day_number(d, m, y);
                low_ok = (op == KIND_ADD);
                if (op == KIND_ADD)
                    total = total + s;
            end
            if (total <= 0)
                res.oor = !low_ok;
            else if (total > days_to_year(MAX_YEAR + 1))
                res.oor = 1'b1;
            else
                res = serial_date(total);
            return res;
        end
    endfunction

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what);
        begin
            $display("mismatch at cycle %0d: %s", cycles, what);
            mismatches++;
        end
    endtask

    // every accepted command queues its expected date
    always @(posedge clk) begin
        if (rst_n && start && !busy) begin
            if (row_typed)
                pending_dates.push_back(row_res);
            else
                pending_dates.push_back(predict_date(kind, longint'(in_day),
                    longint'(in_month), longint'(in_year), longint'(in_serial)));
        end
    end

    // each done strobe is one result transfer, compared with the oldest expectation
    always @(posedge clk) begin
        date_res_t want;
        if (rst_n && done) begin
            if (pending_dates.size() == 0) begin
                report_mismatch("result with nothing expected");
            end else begin
                want = pending_dates.pop_front();
                if (out_day !== want.day)
                    report_mismatch($sformatf("day %0d, want %0d", out_day, want.day));
                if (out_month !== want.month)
                    report_mismatch($sformatf("month %0d, want %0d", out_month, want.month));
                if (out_year !== want.year)
                    report_mismatch($sformatf("year %0d, want %0d", out_year, want.year));
                if (out_serial !== want.serial)
                    report_mismatch($sformatf("serial %0d, want %0d", out_serial, want.serial));
                if (out_of_range !== want.oor)
                    report_mismatch($sformatf("range flag %0b, want %0b",
                                              out_of_range, want.oor));
            end
        end
    end

    // watchdog
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------

    // hold start low for gap cycles, then offer one command until it transfers
    task automatic issue(input logic [1:0] op, input int d, input int m, input int y,
                         input int s, input int gap, input bit typed, input date_res_t res);
        begin
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            start     <= 1'b1;
            kind      <= op;
            in_day    <= 17'(d);
            in_month  <= 13'(m);
            in_year   <= 14'(y);
            in_serial <= 23'(s);
            row_typed <= typed;
            row_res   <= res;
            do @(posedge clk); while (busy);
        end
    endtask

    function automatic int pick_gap(input bit burst);
        return burst ? 0 : int'($urandom_range(0, 16));
    endfunction

    localparam date_res_t EPOCH    = '{5'd1, 4'd1, 14'd1, 22'd1, 1'b0};
    localparam date_res_t SAT      = '{5'd1, 4'd1, 14'd1, 22'd1, 1'b1};
    localparam date_res_t LAST_DAY = '{5'd31, 4'd12, 14'd9999, 22'd3652059, 1'b0};
    localparam date_res_t NONE     = '0;

    date_row_t rows[] = '{
        '{KIND_TO_DATE,   0,      0,     1,     1,        1, EPOCH},
        '{KIND_TO_DATE,   0,      0,     1,     0,        1, EPOCH},
        '{KIND_TO_DATE,   0,      0,     1,     -4194304, 1, EPOCH},
        '{KIND_TO_DATE,   0,      0,     1,     4194303,  1, SAT},
        '{KIND_TO_DATE,   0,      0,     1,     3652059,  1, LAST_DAY},
        '{KIND_TO_DATE,   0,      0,     1,     3652060,  1, SAT},
        '{KIND_TO_DATE,   0,      0,     1,     730179,   0, NONE},
        '{KIND_TO_SERIAL, 1,      1,     1,     0,        1, EPOCH},
        '{KIND_TO_SERIAL, 31,     12,    9999,  0,        1, LAST_DAY},
        '{KIND_TO_SERIAL, 29,     2,     2000,  0,        0, NONE},
        '{KIND_TO_SERIAL, 29,     2,     1900,  0,        0, NONE},
        '{KIND_TO_SERIAL, 1,      3,     2024,  0,        0, NONE},
        '{KIND_TO_SERIAL, 0,      1,     1,     0,        1, SAT},
        '{KIND_TO_SERIAL, 32,     12,    9999,  0,        1, SAT},
        '{KIND_TO_SERIAL, 1,      -4096, 1,     0,        1, SAT},
        '{KIND_NORMALIZE, -65536, 1,     1,     0,        1, SAT},
        '{KIND_NORMALIZE, 65535,  4095,  9999,  0,        1, SAT},
        '{KIND_NORMALIZE, -65536, 4095,  16383, 0,        0, NONE},
        '{KIND_NORMALIZE, 0,      0,     401,   0,        0, NONE},
        '{KIND_NORMALIZE, 65535,  -4096, 16383, 0,        0, NONE},
        '{KIND_ADD,       1,      1,     1,     -1,       1, EPOCH},
        '{KIND_ADD,       31,     12,    9999,  1,        1, SAT},
        '{KIND_ADD,       0,      -4096, 1,     4194303,  0, NONE},
        '{KIND_ADD,       65535,  4095,  16383, -4194304, 0, NONE},
        '{KIND_ADD,       28,     2,     2400,  1,        0, NONE}
    };

    initial begin
        int        d, m, y, s;
        logic [1:0] op;
        bit        burst;
        rst_n      = 1'b0;
        start      = 1'b0;
        kind       = KIND_TO_DATE;
        in_day     = '0;
        in_month   = '0;
        in_year    = '0;
        in_serial  = '0;
        row_typed  = 1'b0;
        row_res    = '0;
        mismatches = 0;
        cycles     = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows, back to back for the first twelve, with random gaps afterwards
        foreach (rows[i])
            issue(rows[i].op, rows[i].d, rows[i].m, rows[i].y, rows[i].s,
                  (i < 12) ? 0 : int'($urandom_range(0, 3)), rows[i].typed, rows[i].res);

        // random part: mostly valid dates and serials, some full range noise
        burst = 1'b0;
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n % 100 == 0)
                burst = ($urandom_range(0, 2) == 0);
            op = 2'($urandom_range(0, 3));
            y  = (($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 16383))
                                              : int'($urandom_range(1, MAX_YEAR)));
            if ($urandom_range(0, 3) == 0) begin
                d = int'(17'($urandom));
                m = int'(13'($urandom));
                d = (d >= 65536) ? d - 131072 : d;
                m = (m >= 4096) ? m - 8192 : m;
            end else begin
                d = $urandom_range(1, 31);
                m = $urandom_range(1, 12);
            end
            case (op)
                KIND_TO_DATE:
                    s = ($urandom_range(0, 4) == 0) ? int'(23'($urandom))
                                                    : int'($urandom_range(1, 3652059));
                KIND_ADD:
                    s = ($urandom_range(0, 4) == 0) ? int'(23'($urandom))
                                                    : int'($urandom_range(0, 200000)) - 100000;
                default:
                    s = int'(23'($urandom));
            endcase
            if (op == KIND_TO_DATE || op == KIND_ADD)
                s = (s >= 4194304) ? s - 8388608 : s;
            issue(op, d, m, y, s, pick_gap(burst), 1'b0, NONE);
        end
        start     <= 1'b0;
        row_typed <= 1'b0;

        // drain the pipeline, then keep watching for stray strobes
        while (pending_dates.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
